/* rtl/sdtq_pkg.sv */
`timescale 1ns / 1ps
package sdtq_pkg;
    localparam int DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] KIND_INSERTED = 3'd0;
    localparam logic [2:0] KIND_REJECTED = 3'd1;
    localparam logic [2:0] KIND_FIRED    = 3'd2;
    localparam logic [2:0] KIND_NONE     = 3'd3;
    localparam logic [2:0] KIND_CLEARED  = 3'd4;

    typedef struct packed {
        logic load;
        logic insert;
        logic tick;
        logic clear;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_due;
        logic empty;
    } stat_t;
endpackage

/* rtl/sdtq_datapath.sv */
`timescale 1ns / 1ps
module sdtq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sdtq_pkg::cmd_t      cmd,
    input  logic [31:0]         delay,
    input  logic [15:0]         action_id,
    input  logic [31:0]         elapsed,
    output sdtq_pkg::stat_t     stat,
    output logic [15:0]         head_id,
    output logic [47:0]         time_now
);
    logic [47:0] dl_reg [sdtq_pkg::DEPTH];
    logic [15:0] id_reg [sdtq_pkg::DEPTH];
    logic [sdtq_pkg::CW-1:0] count_reg;
    logic [47:0] time_reg;
    logic [31:0] delay_reg;
    logic [15:0] aid_reg;
    logic [31:0] elapsed_reg;
    logic [48:0] dl_sum;
    logic [47:0] new_dl;
    logic [48:0] t_sum;

    // The operands are captured on load so the insert and tick work from registers.
    assign dl_sum = {1'b0, time_reg} + {17'd0, delay_reg};
    assign new_dl = dl_sum[48] ? sdtq_pkg::TIME_MAX : dl_sum[47:0];
    assign t_sum  = {1'b0, time_reg} + {17'd0, elapsed_reg};

    assign stat.full     = (count_reg == sdtq_pkg::CW'(sdtq_pkg::DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.head_due = (count_reg != '0) && (dl_reg[0] <= time_reg);
    assign head_id       = id_reg[0];
    assign time_now      = time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            time_reg  <= '0;
        end
        else
        begin
            if (cmd.tick)
                time_reg <= t_sum[48] ? sdtq_pkg::TIME_MAX : t_sum[47:0];
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.insert)
                count_reg <= count_reg + 1'b1;
            else if (cmd.pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            delay_reg   <= delay;
            aid_reg     <= action_id;
            elapsed_reg <= elapsed;
        end
        if (cmd.insert)
        begin
            // Each cell keeps, shifts up or takes the new entry, as in a sorted chain.
            if (count_reg == '0 || dl_reg[0] > new_dl)
            begin
                dl_reg[0] <= new_dl;
                id_reg[0] <= aid_reg;
            end
            for (int i = 1; i < sdtq_pkg::DEPTH; i++)
            begin
                if (sdtq_pkg::CW'(i - 1) < count_reg && dl_reg[i - 1] > new_dl)
                begin
                    dl_reg[i] <= dl_reg[i - 1];
                    id_reg[i] <= id_reg[i - 1];
                end
                if (sdtq_pkg::CW'(i) <= count_reg && dl_reg[i - 1] <= new_dl &&
                        (sdtq_pkg::CW'(i) == count_reg || dl_reg[i] > new_dl))
                begin
                    dl_reg[i] <= new_dl;
                    id_reg[i] <= aid_reg;
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < sdtq_pkg::DEPTH - 1; i++)
            begin
                dl_reg[i] <= dl_reg[i + 1];
                id_reg[i] <= id_reg[i + 1];
            end
        end
    end
endmodule

/* rtl/sdtq_ctrl.sv */
`timescale 1ns / 1ps
module sdtq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        kind,
    output logic [15:0]       fired_id,
    output logic              last,
    output logic [47:0]       now_time,
    output sdtq_pkg::cmd_t    cmd,
    input  sdtq_pkg::stat_t   stat,
    input  logic [15:0]       head_id,
    input  logic [47:0]       time_now
);
    typedef enum logic [2:0] {S_IDLE, S_INS, S_TICK, S_FIRE, S_OUT} state_t;
    state_t state_reg;
    logic [1:0] op_reg;
    logic [4:0] n_reg;
    logic free;
    logic take;

    // The output register may be reloaded as soon as its item is taken.
    assign free     = !out_valid || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !free;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        cmd = '0;
        cmd.load = take;
        case (state_reg)
            S_INS:  cmd.insert = !stat.full && free;
            S_TICK: cmd.tick = 1'b1;
            S_FIRE: cmd.pop = free && stat.head_due && (n_reg < 5'(sdtq_pkg::MAX_RESULTS));
            S_OUT:  cmd.clear = free && (op_reg == sdtq_pkg::OP_CLEAR);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            op_reg    <= '0;
            n_reg     <= '0;
            kind      <= '0;
            fired_id  <= '0;
            last      <= 1'b0;
            now_time  <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (take)
                    begin
                        op_reg <= opcode;
                        case (opcode)
                            sdtq_pkg::OP_INSERT: state_reg <= S_INS;
                            sdtq_pkg::OP_TICK:   state_reg <= S_TICK;
                            sdtq_pkg::OP_CLEAR:  state_reg <= S_OUT;
                            default:             state_reg <= S_IDLE;
                        endcase
                    end
                S_INS:
                    if (free)
                    begin
                        out_valid <= 1'b1;
                        kind      <= stat.full ? sdtq_pkg::KIND_REJECTED
                                               : sdtq_pkg::KIND_INSERTED;
                        fired_id  <= '0;
                        last      <= 1'b1;
                        now_time  <= time_now;
                        state_reg <= S_IDLE;
                    end
                S_TICK:
                begin
                    n_reg     <= '0;
                    state_reg <= S_FIRE;
                end
                S_FIRE:
                    if (free)
                    begin
                        if (cmd.pop)
                        begin
                            // The fired item is held back until the next head is known.
                            kind      <= sdtq_pkg::KIND_FIRED;
                            fired_id  <= head_id;
                            now_time  <= time_now;
                            n_reg     <= n_reg + 5'd1;
                            last      <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else if (n_reg == '0)
                        begin
                            out_valid <= 1'b1;
                            kind      <= sdtq_pkg::KIND_NONE;
                            fired_id  <= '0;
                            last      <= 1'b1;
                            now_time  <= time_now;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                S_OUT:
                    if (op_reg == sdtq_pkg::OP_CLEAR)
                    begin
                        if (free)
                        begin
                            out_valid <= 1'b1;
                            kind      <= sdtq_pkg::KIND_CLEARED;
                            fired_id  <= '0;
                            last      <= 1'b1;
                            now_time  <= time_now;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // The head now shows whether another entry is due, so last is
                        // settled before the fired item is offered.
                        out_valid <= 1'b1;
                        if (!(stat.head_due && (n_reg < 5'(sdtq_pkg::MAX_RESULTS))))
                        begin
                            last      <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_FIRE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/sorted_deadline_timer_queue.sv */
`timescale 1ns / 1ps
// Sorted timer queue holding up to sdtq_pkg::DEPTH actions in deadline order.
// Input channel: in_valid/in_stall with opcode, delay, action_id, elapsed.
// Output channel: out_valid/out_stall with kind, fired_id, last, now_time.
// An insert registers its operands on acceptance; then, unless the queue is
// full and the entry is rejected, the sorted register chain shifts and places
// the entry in one step. Its single result enters the output register from
// the S_INS state, which waits for a free output register. A clear likewise
// gives one result, from the S_OUT state once the output register is free.
// A tick updates the time in the cycle after acceptance, then pops due
// entries one at a time, passing through S_FIRE and S_OUT for each, up to 16
// per tick, each popped entry giving one fired item; S_FIRE waits for a free
// output register, and the last item of a tick carries last = 1. A tick with
// nothing due gives one none-fired item from the S_FIRE state. The next input
// item is accepted once the final result of the current one leaves the output
// register, at the earliest in the same cycle; items are taken one at a time.
// When the receiver stalls, the output register holds its item and the
// controller waits. Reset empties the queue and sets the time to zero.
module sorted_deadline_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] delay,
    input  logic [15:0] action_id,
    input  logic [31:0] elapsed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [15:0] fired_id,
    output logic        last,
    output logic [47:0] now_time
);
    sdtq_pkg::cmd_t  cmd;
    sdtq_pkg::stat_t stat;
    logic [15:0] head_id;
    logic [47:0] time_now;

    sdtq_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .opcode, .out_valid, .out_stall,
        .kind, .fired_id, .last, .now_time, .cmd, .stat, .head_id, .time_now
    );

    sdtq_datapath u_dp (
        .clk, .rst_n, .cmd, .delay, .action_id, .elapsed, .stat, .head_id, .time_now
    );

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && stat.full)) else $error("insert into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pop && stat.empty)) else $error("pop from empty queue");
    a_fired_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != sdtq_pkg::KIND_FIRED |-> fired_id == '0)
        else $error("fired_id not zero");
endmodule

/* sim/sdtq_checker.sv */
`timescale 1ns / 1ps
module sdtq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] delay,
    input  logic [15:0] action_id,
    input  logic [31:0] elapsed,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] fired_id,
    input  logic        last,
    input  logic [47:0] now_time,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic        last;
        logic [47:0] now;
    } timer_event_t;

    timer_event_t event_queue[$];
    logic [47:0]  q_deadline[sdtq_pkg::DEPTH];
    logic [15:0]  q_id[sdtq_pkg::DEPTH];
    int           q_count;
    logic [47:0]  clock_now;

    function automatic logic [47:0] add_sat(logic [47:0] base, logic [31:0] add);
        logic [48:0] s;
        s = {1'b0, base} + {17'b0, add};
        return s[48] ? sdtq_pkg::TIME_MAX : s[47:0];
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic push_event(logic [2:0] k, logic [15:0] id, logic l);
        timer_event_t e;
        e.kind = k;
        e.id = id;
        e.last = l;
        e.now = clock_now;
        event_queue.push_back(e);
    endtask

    task automatic predict_item(logic [1:0] op, logic [31:0] dly, logic [15:0] aid,
                                logic [31:0] el);
        logic [47:0] dl;
        int          pos;
        int          n;
        case (op)
            sdtq_pkg::OP_INSERT:
                if (q_count >= sdtq_pkg::DEPTH)
                    push_event(sdtq_pkg::KIND_REJECTED, 16'd0, 1'b1);
                else
                begin
                    dl = add_sat(clock_now, dly);
                    pos = q_count;
                    while (pos > 0 && q_deadline[pos-1] > dl)
                    begin
                        q_deadline[pos] = q_deadline[pos-1];
                        q_id[pos] = q_id[pos-1];
                        pos--;
                    end
                    q_deadline[pos] = dl;
                    q_id[pos] = aid;
                    q_count++;
                    push_event(sdtq_pkg::KIND_INSERTED, 16'd0, 1'b1);
                end
            sdtq_pkg::OP_TICK:
            begin
                clock_now = add_sat(clock_now, el);
                n = 0;
                while (n < q_count && n < sdtq_pkg::MAX_RESULTS &&
                       q_deadline[n] <= clock_now)
                    n++;
                if (n == 0) push_event(sdtq_pkg::KIND_NONE, 16'd0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_event(sdtq_pkg::KIND_FIRED, q_id[i], i + 1 == n);
                for (int i = n; i < q_count; i++)
                begin
                    q_deadline[i-n] = q_deadline[i];
                    q_id[i-n] = q_id[i];
                end
                q_count -= n;
            end
            sdtq_pkg::OP_CLEAR:
            begin
                q_count = 0;
                push_event(sdtq_pkg::KIND_CLEARED, 16'd0, 1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_event_t e;
        if (!rst_n)
        begin
            event_queue.delete();
            q_count = 0;
            clock_now = '0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall) predict_item(opcode, delay, action_id, elapsed);
            if (out_valid && !out_stall)
            begin
                if (event_queue.size() == 0) report("result with nothing expected");
                else
                begin
                    e = event_queue.pop_front();
                    if (kind !== e.kind)
                        report($sformatf("kind %0d, expected %0d", kind, e.kind));
                    if (fired_id !== e.id)
                        report($sformatf("fired_id %0h, expected %0h", fired_id, e.id));
                    if (last !== e.last)
                        report($sformatf("last %0b, expected %0b", last, e.last));
                    if (now_time !== e.now)
                        report($sformatf("now_time %0h, expected %0h", now_time, e.now));
                end
            end
            pending = event_queue.size();
        end
    end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = sdtq_pkg::OP_TICK;
    logic [31:0] delay = '0;
    logic [15:0] action_id = '0;
    logic [31:0] elapsed = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [15:0] fired_id;
    logic        last;
    logic [47:0] now_time;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          done = 1'b0;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    sorted_deadline_timer_queue dut (.*);

    sdtq_checker checker_i (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Valid stays high between items sent back to back and drops only for a gap.
    task automatic send_item(logic [1:0] op, logic [31:0] dly, logic [15:0] aid,
                             logic [31:0] el);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        delay <= dly;
        action_id <= aid;
        elapsed <= el;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_span();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            2: return 0;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Receiver: random stalls, with one long hold-off once the queue has been filled.
    always @(posedge clk)
    begin
        if (hold_off) out_stall <= 1'b1;
        else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
        else if (out_stall && $urandom_range(0, 9) != 0) out_stall <= 1'b1;
        else out_stall <= $urandom_range(0, 5) == 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && !done)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** sorted_deadline_timer_queue: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: nothing due, empty clear, ordering, ties, full.
        send_item(sdtq_pkg::OP_TICK, '0, '0, '0);
        send_item(sdtq_pkg::OP_CLEAR, '0, '0, '0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(sdtq_pkg::OP_INSERT, 32'd5, 16'h0001, '0);
        send_item(sdtq_pkg::OP_INSERT, 32'd5, 16'h0002, '0);
        send_item(sdtq_pkg::OP_INSERT, 32'd0, 16'hFFFF, '0);
        send_item(sdtq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h0000, '0);
        send_item(sdtq_pkg::OP_TICK, '0, '0, 32'd4);
        send_item(sdtq_pkg::OP_TICK, '0, '0, 32'd1);
        for (int i = 0; i < 15; i++)
            send_item(sdtq_pkg::OP_INSERT, 32'd3, 16'(16'hA000 + i), '0);
        send_item(sdtq_pkg::OP_INSERT, 32'd1, 16'h5555, '0);
        send_item(sdtq_pkg::OP_TICK, '0, '0, 32'd10);
        wait_drained();

        // Fill the queue with far deadlines.
        for (int i = 0; i < 16; i++)
            send_item(sdtq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'(i), '0);
        // Receiver holds off while the sender keeps offering.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 4; i++)
                    send_item(sdtq_pkg::OP_INSERT, 32'd1, 16'hBEEF, '0);
            end
        join
        wait_drained();
        send_item(sdtq_pkg::OP_TICK, '0, '0, 32'hFFFF_FFFF);
        send_item(sdtq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h1234, '0);
        send_item(sdtq_pkg::OP_TICK, '0, '0, 32'd0);
        wait_drained();

        // Random phase with a mix of short and long time steps.
        for (int i = 0; i < 430; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(sdtq_pkg::OP_INSERT, rand_span(), 16'($urandom()), $urandom());
            else if (r < 90)
                send_item(sdtq_pkg::OP_TICK, $urandom(), 16'($urandom()), rand_span());
            else if (r < 96)
                send_item(sdtq_pkg::OP_CLEAR, $urandom(), 16'($urandom()), $urandom());
            else
                send_item(OP_UNUSED, $urandom(), 16'($urandom()), $urandom());
            if (i == 215) wait_drained();
        end
        wait_drained();
        repeat (40) @(posedge clk);
        done = 1'b1;
        if (fail_count == 0) $display("** sorted_deadline_timer_queue: PASSED **");
        else $display("** sorted_deadline_timer_queue: FAILED **");
        $finish;
    end
endmodule

/* files.f */
rtl/sdtq_pkg.sv
rtl/sdtq_datapath.sv
rtl/sdtq_ctrl.sv
rtl/sorted_deadline_timer_queue.sv
sim/sdtq_checker.sv
sim/tb_top.sv
